// ===== rtl/sha256_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial vector, shared types and helper functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

   localparam int QueueDepth = 4;

   typedef logic [31:0] word_type;

   // beat handed from the front end to the compression engine
   typedef struct packed {
      logic [7:0] data;
      logic       valid_byte;
      logic       last;
   } cmd_type;

   function automatic word_type round_k(input logic [5:0] r);
      word_type k;
      unique case (r)
         6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic word_type init_hash(input logic [2:0] i);
      word_type h;
      unique case (i)
         3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
         3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
         3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
         3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
      endcase
      return h;
   endfunction

   function automatic word_type ror(input word_type v, input int s);
      return (v >> s) | (v << (32 - s));
   endfunction

endpackage

// ===== rtl/sha256_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream interfaces
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
interface sha256_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] message_byte;
   logic       byte_valid;
   logic       last_byte;
   modport source (output valid, message_byte, byte_valid, last_byte, input ready);
   modport sink (input valid, message_byte, byte_valid, last_byte, output ready);
endinterface

interface sha256_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== rtl/sha256_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts beats, drops idle ones and queues the rest for the engine.
// ----------------------------------------------------------------------------
module sha256_front #(
   parameter int Depth = sha256_pkg::QueueDepth
) (
   input  logic                 clock,
   input  logic                 reset,
   sha256_req_if.sink           req,
   output sha256_pkg::cmd_type  cmd,
   output logic                 cmd_valid,
   input  logic                 cmd_pop
);
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   sha256_pkg::cmd_type q_ff [Depth];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          push;

   assign req.ready = (cnt_ff != (AW+1)'(Depth));
   // idle beats are swallowed here
   assign push      = req.valid && req.ready && (req.byte_valid || req.last_byte);
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rd_ff];

   // pointer update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(Depth-1)) ? '0 : wr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_in = (rd_ff == AW'(Depth-1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= '{data: req.message_byte, valid_byte: req.byte_valid,
                          last: req.last_byte};
      end
   end
endmodule

// ===== rtl/sha256_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 engine
// Packs bytes into blocks, pads, runs one round per cycle, emits the digest.
// ----------------------------------------------------------------------------
module sha256_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  sha256_pkg::cmd_type  cmd,
   input  logic                 cmd_valid,
   output logic                 cmd_pop,
   sha256_rsp_if.source         rsp
);
   localparam logic [2:0] S_FILL  = 3'd0;
   localparam logic [2:0] S_PAD   = 3'd1;
   localparam logic [2:0] S_ROUND = 3'd2;
   localparam logic [2:0] S_FOLD  = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   logic [2:0]  st_ff, st_in;
   sha256_pkg::word_type buf_ff [16];
   sha256_pkg::word_type w_ff [16];
   sha256_pkg::word_type h_ff [8];
   sha256_pkg::word_type v_ff [8];
   logic [60:0] total_ff;
   logic [5:0]  fill_ff;
   logic [5:0]  rnd_ff;
   logic        final_ff;   // block in flight ends the message
   logic        extra_ff;   // a length-only block follows
   logic        pend_ff;    // last beat closed a full block, padding block follows
   logic [2:0]  oidx_ff;

   sha256_pkg::word_type wt, s0, s1, x15, x2, t1, t2, e, a;
   logic [3:0] ri;
   logic       len_here;    // this padding block carries the bit length
   logic [63:0] bit_len;

   assign len_here = extra_ff || (fill_ff < 6'd56);
   assign bit_len  = {total_ff, 3'd0};

   // message schedule and round datapath
   always_comb begin
      ri  = rnd_ff[3:0];
      x15 = w_ff[4'(ri + 4'd1)];
      x2  = w_ff[4'(ri + 4'd14)];
      s0  = sha256_pkg::ror(x15, 7) ^ sha256_pkg::ror(x15, 18) ^ (x15 >> 3);
      s1  = sha256_pkg::ror(x2, 17) ^ sha256_pkg::ror(x2, 19) ^ (x2 >> 10);
      wt  = (rnd_ff < 6'd16) ? w_ff[ri] : w_ff[ri] + s0 + w_ff[4'(ri + 4'd9)] + s1;
      e   = v_ff[4];
      a   = v_ff[0];
      t1  = v_ff[7] + (sha256_pkg::ror(e, 6) ^ sha256_pkg::ror(e, 11)
            ^ sha256_pkg::ror(e, 25)) + ((e & v_ff[5]) ^ (~e & v_ff[6]))
            + sha256_pkg::round_k(rnd_ff) + wt;
      t2  = (sha256_pkg::ror(a, 2) ^ sha256_pkg::ror(a, 13) ^ sha256_pkg::ror(a, 22))
            + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   assign cmd_pop         = (st_ff == S_FILL) && cmd_valid;
   assign rsp.valid       = (st_ff == S_OUT);
   assign rsp.digest_word = h_ff[oidx_ff];
   assign rsp.word_index  = oidx_ff;
   assign rsp.last_word   = (oidx_ff == 3'd7);

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_FILL: begin
            if (cmd_valid) begin
               if (cmd.valid_byte && fill_ff == 6'd63) begin
                  st_in = S_ROUND;
               end else if (cmd.last) begin
                  st_in = S_PAD;
               end
            end
         end
         S_PAD:   st_in = S_ROUND;
         S_ROUND: st_in = (rnd_ff == 6'd63) ? S_FOLD : S_ROUND;
         S_FOLD: begin
            if (extra_ff || pend_ff) begin
               st_in = S_PAD;
            end else if (final_ff) begin
               st_in = S_OUT;
            end else begin
               st_in = S_FILL;
            end
         end
         S_OUT:   st_in = (rsp.ready && oidx_ff == 3'd7) ? S_FILL : S_OUT;
         default: st_in = S_FILL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= S_FILL;
         total_ff <= '0;
         fill_ff  <= '0;
         rnd_ff   <= '0;
         final_ff <= 1'b0;
         extra_ff <= 1'b0;
         pend_ff  <= 1'b0;
         oidx_ff  <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= sha256_pkg::init_hash(3'(i));
      end else begin
         st_ff <= st_in;
         unique case (st_ff)
            // byte packing; a full block starts the rounds
            S_FILL: begin
               if (cmd_valid) begin
                  if (cmd.valid_byte) begin
                     if (fill_ff[1:0] == 2'd0) begin
                        buf_ff[fill_ff[5:2]] <= {cmd.data, 24'd0};
                     end else begin
                        buf_ff[fill_ff[5:2]] <= buf_ff[fill_ff[5:2]]
                           | (32'(cmd.data) << (5'(3 - fill_ff[1:0]) * 5'd8));
                     end
                     fill_ff  <= fill_ff + 6'd1;
                     total_ff <= total_ff + 61'd1;
                  end
                  final_ff <= cmd.last;
                  if (cmd.valid_byte && fill_ff == 6'd63) begin
                     for (int i = 0; i < 15; i++) w_ff[i] <= buf_ff[i];
                     w_ff[15] <= {buf_ff[15][31:8], cmd.data};
                     for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
                     rnd_ff   <= '0;
                     extra_ff <= 1'b0;
                     pend_ff  <= cmd.last;
                  end
               end
            end
            // padding block, built straight into the schedule window
            S_PAD: begin
               for (int i = 0; i < 16; i++) begin
                  if (len_here && i >= 14) begin
                     w_ff[i] <= (i == 14) ? bit_len[63:32] : bit_len[31:0];
                  end else if (extra_ff || 4'(i) > fill_ff[5:2]) begin
                     w_ff[i] <= '0;
                  end else if (4'(i) < fill_ff[5:2]) begin
                     w_ff[i] <= buf_ff[i];
                  end else begin
                     unique case (fill_ff[1:0])
                        2'd0: w_ff[i] <= 32'h8000_0000;
                        2'd1: w_ff[i] <= {buf_ff[i][31:24], 24'h80_0000};
                        2'd2: w_ff[i] <= {buf_ff[i][31:16], 16'h8000};
                        default: w_ff[i] <= {buf_ff[i][31:8], 8'h80};
                     endcase
                  end
               end
               extra_ff <= !len_here;
               pend_ff  <= 1'b0;
               final_ff <= 1'b1;
               fill_ff  <= '0;
               rnd_ff   <= '0;
               for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
            end
            // one round per cycle
            S_ROUND: begin
               if (rnd_ff >= 6'd16) w_ff[ri] <= wt;
               for (int i = 7; i > 0; i--) begin
                  if (i != 4) v_ff[i] <= v_ff[i-1];
               end
               v_ff[4] <= v_ff[3] + t1;
               v_ff[0] <= t1 + t2;
               rnd_ff  <= rnd_ff + 6'd1;
            end
            S_FOLD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               if (final_ff && !extra_ff) oidx_ff <= '0;
            end
            // digest words, then back to the initial vector
            S_OUT: begin
               if (rsp.ready) begin
                  oidx_ff <= oidx_ff + 3'd1;
                  if (oidx_ff == 3'd7) begin
                     for (int i = 0; i < 8; i++) h_ff[i] <= sha256_pkg::init_hash(3'(i));
                     total_ff <= '0;
                     fill_ff  <= '0;
                     final_ff <= 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end
   end
endmodule

// ===== rtl/sha256_message_hasher_unit.sv =====
`timescale 1ns / 1ps
// Byte beats are taken at one per cycle into a small queue while it has room; the engine packs one
// byte per cycle while filling and runs 64 rounds and a fold on each full block.
// A last beat is followed by a padding block, and by a length-only block as well when
// the padding spills past the end of the block, then eight digest words leave at
// one per cycle under backpressure.
// Synchronous reset restores the initial vector and clears counts and queue.
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Front end queue feeding a round-per-cycle compression engine.
// ----------------------------------------------------------------------------
module sha256_message_hasher_unit #(
   parameter int QueueDepth = sha256_pkg::QueueDepth
) (
   input  logic         clock,
   input  logic         reset,
   sha256_req_if.sink   req,
   sha256_rsp_if.source rsp
);
   sha256_pkg::cmd_type cmd;
   logic                cmd_valid;
   logic                cmd_pop;

   sha256_front #(.Depth(QueueDepth)) u_front (
      .clock, .reset, .req, .cmd, .cmd_valid, .cmd_pop
   );

   sha256_engine u_engine (
      .clock, .reset, .cmd, .cmd_valid, .cmd_pop, .rsp
   );
endmodule

// ===== verif/sha256_scoreboard.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 digest scoreboard
// Tracks message bytes as they are accepted, computes the digest of each
// finished message and checks the digest words that leave the block.
// ----------------------------------------------------------------------------
class sha256_scoreboard;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_beat_type;

   logic [31:0]     chain[8];
   logic [31:0]     blk[16];
   logic [60:0]     byte_count;
   logic [5:0]      fill;
   digest_beat_type pending_words[$];
   int              fail_count;
   int              words_checked;
   int              messages_done;

   function new();
      fail_count = 0;
      words_checked = 0;
      messages_done = 0;
      restart();
   endfunction

   function void restart();
      chain = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      byte_count = '0;
      fill = '0;
   endfunction

   function logic [31:0] rotr(logic [31:0] v, int s);
      return (v >> s) | (v << (32 - s));
   endfunction

   // one 64-round compression of blk into chain
   function void compress();
      logic [31:0] w[64];
      logic [31:0] v[8];
      logic [31:0] t1, t2, s0, s1;
      for (int r = 0; r < 64; r++) begin
         if (r < 16) begin
            w[r] = blk[r];
         end else begin
            s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
            s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
            w[r] = w[r-16] + s0 + w[r-7] + s1;
         end
      end
      v = chain;
      for (int r = 0; r < 64; r++) begin
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::round_k(r[5:0]) + w[r];
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         for (int k = 7; k > 0; k--) v[k] = v[k-1];
         v[4] += t1;
         v[0] = t1 + t2;
      end
      for (int k = 0; k < 8; k++) chain[k] += v[k];
   endfunction

   function void place_byte(logic [5:0] pos, logic [7:0] b);
      int sh;
      sh = (3 - pos[1:0]) * 8;
      if (pos[1:0] == 2'd0) blk[pos[5:2]] = 32'(b) << sh;
      else blk[pos[5:2]] |= 32'(b) << sh;
   endfunction

   // note an accepted beat; a last beat queues eight digest words
   function void note_input(logic [7:0] data, logic has_byte, logic ends_msg);
      logic [63:0] bit_len;
      if (has_byte) begin
         place_byte(fill, data);
         fill++;
         byte_count++;
         if (fill == 0) compress();
      end
      if (!ends_msg) return;
      place_byte(fill, 8'h80);
      for (int k = fill[5:2] + 1; k < 16; k++) blk[k] = '0;
      if (fill >= 56) begin
         compress();
         for (int k = 0; k < 16; k++) blk[k] = '0;
      end
      bit_len = {byte_count, 3'b000};
      blk[14] = bit_len[63:32];
      blk[15] = bit_len[31:0];
      compress();
      for (int k = 0; k < 8; k++)
         pending_words.push_back('{chain[k], 3'(k), k == 7});
      messages_done++;
      restart();
   endfunction

   function void check_output(logic [31:0] dw, logic [2:0] idx, logic lw);
      digest_beat_type e;
      if (pending_words.size() == 0) begin
         $error("digest word %h with nothing expected", dw);
         fail_count++;
         return;
      end
      e = pending_words.pop_front();
      words_checked++;
      if (dw !== e.digest_word) begin
         $error("digest_word: expected %h, got %h", e.digest_word, dw);
         fail_count++;
      end
      if (idx !== e.word_index) begin
         $error("word_index: expected %0d, got %0d", e.word_index, idx);
         fail_count++;
      end
      if (lw !== e.last_word) begin
         $error("last_word: expected %0b, got %0b", e.last_word, lw);
         fail_count++;
      end
   endfunction

endclass

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Feeds directed and random byte messages with random gaps and backpressure,
// and checks every digest word against a behavioural SHA-256 model.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int WatchdogLimit = 20000;
   localparam int DrainCycles = 300;

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   quiet_cycles;
   int   beats_sent;
   bit   timed_out;

   sha256_req_if req ();
   sha256_rsp_if rsp ();
   sha256_scoreboard sb;

   sha256_message_hasher_unit uut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // receiver: ready toggles at the falling edge, words checked at the rising edge
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         sb.check_output(rsp.digest_word, rsp.word_index, rsp.last_word);
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("watchdog expired");
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // one beat on the request channel, with an optional idle gap before it;
   // valid stays up after the beat until the next call or a drain
   task automatic send_beat(logic [7:0] data, logic has_byte, logic ends_msg);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid        <= 1'b1;
      req.message_byte <= data;
      req.byte_valid   <= has_byte;
      req.last_byte    <= ends_msg;
      do @(posedge clock); while (!req.ready);
      if (has_byte || ends_msg) sb.note_input(data, has_byte, ends_msg);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic send_message(int len, int pattern);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         case (pattern)
            0: b = 8'h00;
            1: b = 8'hff;
            default: b = 8'($urandom);
         endcase
         // the final byte sometimes rides on the last beat
         if (i == len - 1 && $urandom_range(1)) begin
            send_beat(b, 1'b1, 1'b1);
            return;
         end
         send_beat(b, 1'b1, 1'b0);
         if ($urandom_range(9) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      end
      send_beat(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (sb.pending_words.size() != 0) @(negedge clock);
   endtask

   initial begin
      int len;
      sb = new();
      send_idle_pct = 36;
      recv_idle_pct = 48;
      beats_sent = 0;
      req.valid = 1'b0;
      req.message_byte = '0;
      req.byte_valid = 1'b0;
      req.last_byte = 1'b0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: idle beat, empty message, byte extremes, padding boundaries
      send_beat(8'hff, 1'b0, 1'b0);
      send_beat(8'h00, 1'b0, 1'b1);
      send_message(1, 0);
      send_message(1, 1);
      send_message(3, 2);
      send_message(55, 2);
      send_message(56, 1);
      send_message(64, 2);
      wait_drained();
      // a five-byte all-zero message once everything is out
      send_message(5, 0);

      // random messages, idling profile switched as the run goes on
      while (beats_sent < 320) begin
         if (beats_sent > 270) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (beats_sent > 220) begin
            send_idle_pct = 48;
            recv_idle_pct = 36;
         end
         len = ($urandom_range(9) == 0) ? $urandom_range(70) : $urandom_range(12);
         send_message(len, $urandom_range(5) == 0 ? $urandom_range(1) : 2);
      end

      wait_drained();
      repeat (DrainCycles) @(negedge clock);
      $display("Ran %0d beats, %0d messages, %0d digest words checked.",
               beats_sent, sb.messages_done, sb.words_checked);
      if (sb.fail_count == 0 && sb.pending_words.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
